// ----- hw/rtl/iems_pkg.sv -----
// shared types and constants for the i2c eeprom master sequencer
// no dependencies; imported by every module of the block but iems_fifo
package iems_pkg;

  localparam int BUF_DEPTH_DEF = 256;
  localparam logic [7:0] MSB_MASK = 8'h80;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_NAK = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [10:0] {
    PH_IDLE     = 11'b000_0000_0001,
    PH_START_A  = 11'b000_0000_0010,
    PH_DEV_W    = 11'b000_0000_0100,
    PH_ADDR_H   = 11'b000_0000_1000,
    PH_ADDR_L   = 11'b000_0001_0000,
    PH_WDATA    = 11'b000_0010_0000,
    PH_STOP_MID = 11'b000_0100_0000,
    PH_START_B  = 11'b000_1000_0000,
    PH_DEV_R    = 11'b001_0000_0000,
    PH_RDATA    = 11'b010_0000_0000,
    PH_STOP_END = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       sda_in;
    logic [7:0] device_address;
    logic [7:0] word_address_high;
    logic [7:0] word_address_low;
    logic [7:0] count;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_last;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t       kind;
    logic       zero_count;
    logic       sda_in;
    logic [7:0] device_address;
    logic [7:0] word_address_high;
    logic [7:0] word_address_low;
    logic [7:0] count;
    logic [7:0] data;
  } op_t;

endpackage

// ----- hw/rtl/iems_fifo.sv -----
// two-entry queue for any packed item type
// no dependencies; used between front and back and on the result side
module iems_fifo #(
  parameter type item_t = logic [7:0]
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full    = (fill == 2'd2);
  assign empty   = (fill == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- hw/rtl/iems_front.sv -----
// front end: takes request items, decodes the command, queues them for the back end
// depends on iems_pkg and iems_fifo
module iems_front import iems_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  request_t request,
  output logic     full,
  output op_t      op,
  output logic     op_valid,
  input  logic     op_take
);

  op_t  op_in;
  logic op_empty;

  always_comb begin
    op_in.kind              = cmd_t'(request.cmd);
    op_in.zero_count        = (request.count == 8'd0);
    op_in.sda_in            = request.sda_in;
    op_in.device_address    = request.device_address;
    op_in.word_address_high = request.word_address_high;
    op_in.word_address_low  = request.word_address_low;
    op_in.count             = request.count;
    op_in.data              = request.data;
  end

  iems_fifo #(.item_t(op_t)) u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (op_in),
    .full  (full),
    .pop   (op_take),
    .rdata (op),
    .empty (op_empty)
  );

  assign op_valid = !op_empty;

endmodule

// ----- hw/rtl/iems_back.sv -----
// back end: bus waveform sequencer and write byte buffer, taking one item per
// cycle while the result queue has room; depends on iems_pkg
module iems_back import iems_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  op_t     op,
  input  logic    op_valid,
  output logic    op_take,
  output result_t result,
  output logic    result_push,
  input  logic    result_full
);

  localparam int LW = $clog2(BUF_DEPTH + 1);
  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  localparam logic [4:0] STEP_EDGE_LAST = 5'd3;
  localparam logic [4:0] STEP_LAST_BIT  = 5'd23;
  localparam logic [4:0] STEP_ACK_SET   = 5'd24;
  localparam logic [4:0] STEP_ACK_HIGH  = 5'd25;
  localparam logic [1:0] SUB_SET        = 2'd0;
  localparam logic [1:0] SUB_HIGH       = 2'd1;
  localparam logic [1:0] SUB_LAST       = 2'd2;

  logic [7:0] buf_mem [BUF_DEPTH];
  logic [7:0] rd_data;

  phase_t     phase, phase_next;
  logic [4:0] bit_step, bit_step_next;
  logic [1:0] sub, sub_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] saved_device, saved_device_next;
  logic [7:0] saved_addr_high, saved_addr_high_next;
  logic [7:0] saved_addr_low, saved_addr_low_next;
  logic [7:0] saved_count, saved_count_next;
  logic       is_read, is_read_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic [LW-1:0] loaded_bytes, loaded_bytes_next;

  logic          go;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [8:0]    next_index;
  logic          last_byte;
  logic          rd_req;
  logic          rx_valid, rx_last, done;
  logic [7:0]    rx_data;
  status_t       status;

  assign go          = op_valid && !result_full;
  assign op_take     = go;
  assign result_push = go;
  assign next_index  = {1'b0, byte_index} + 9'd1;
  assign last_byte   = (next_index >= {1'b0, saved_count});

  always_comb begin
    phase_next           = phase;
    bit_step_next        = bit_step;
    sub_next             = sub;
    byte_index_next      = byte_index;
    shift_byte_next      = shift_byte;
    saved_device_next    = saved_device;
    saved_addr_high_next = saved_addr_high;
    saved_addr_low_next  = saved_addr_low;
    saved_count_next     = saved_count;
    is_read_next         = is_read;
    scl_level_next       = scl_level;
    sda_level_next       = sda_level;
    loaded_bytes_next    = loaded_bytes;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    rd_addr              = '0;
    rd_req               = 1'b0;
    rx_valid             = 1'b0;
    rx_last              = 1'b0;
    rx_data              = 8'd0;
    done                 = 1'b0;
    status               = ST_OK;

    if (phase == PH_IDLE) begin
      case (op.kind)
        CMD_LOAD: begin
          if (loaded_bytes < LW'(BUF_DEPTH)) begin
            wr_en             = 1'b1;
            loaded_bytes_next = LW'(loaded_bytes + 1'b1);
          end
        end
        CMD_WRITE, CMD_READ: begin
          rd_req = (op.kind == CMD_READ);
          if ((rd_req && op.zero_count) ||
              (!rd_req && ({1'b0, op.count} > 9'(loaded_bytes)))) begin
            done   = 1'b1;
            status = ST_BAD;
          end else begin
            is_read_next         = rd_req;
            saved_device_next    = op.device_address;
            saved_addr_high_next = op.word_address_high;
            saved_addr_low_next  = op.word_address_low;
            saved_count_next     = op.count;
            if (!rd_req) begin
              loaded_bytes_next = '0;
            end
            phase_next      = PH_START_A;
            bit_step_next   = 5'd0;
            sub_next        = SUB_SET;
            byte_index_next = 8'd0;
          end
        end
        default: ;
      endcase
    end else if (op.kind == CMD_TICK) begin
      case (phase)
        PH_START_A, PH_START_B: begin
          case (bit_step)
            5'd0:    scl_level_next = 1'b1;
            5'd1:    sda_level_next = 1'b1;
            5'd2:    sda_level_next = 1'b0;
            default: scl_level_next = 1'b0;
          endcase
          if (bit_step >= STEP_EDGE_LAST) begin
            bit_step_next = 5'd0;
            sub_next      = SUB_SET;
            if (phase == PH_START_A) begin
              phase_next      = PH_DEV_W;
              shift_byte_next = saved_device;
            end else begin
              phase_next      = PH_DEV_R;
              shift_byte_next = saved_device + 8'd1;
            end
          end else begin
            bit_step_next = bit_step + 5'd1;
          end
        end
        PH_STOP_MID, PH_STOP_END: begin
          case (bit_step)
            5'd0:    sda_level_next = 1'b0;
            5'd1:    scl_level_next = 1'b1;
            5'd2:    sda_level_next = 1'b1;
            default: scl_level_next = 1'b1;
          endcase
          if (bit_step >= STEP_EDGE_LAST) begin
            bit_step_next = 5'd0;
            sub_next      = SUB_SET;
            if (phase == PH_STOP_MID) begin
              phase_next = PH_START_B;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
              status     = ST_OK;
            end
          end else begin
            bit_step_next = bit_step + 5'd1;
          end
        end
        PH_RDATA: begin
          if (bit_step < STEP_ACK_SET) begin
            case (sub)
              SUB_SET:  sda_level_next = 1'b1;
              SUB_HIGH: scl_level_next = 1'b1;
              default: begin
                scl_level_next  = 1'b0;
                shift_byte_next = {shift_byte[6:0], op.sda_in};
                if (bit_step == STEP_LAST_BIT) begin
                  rx_valid = 1'b1;
                  rx_data  = shift_byte_next;
                  rx_last  = last_byte;
                end
              end
            endcase
            bit_step_next = bit_step + 5'd1;
            sub_next      = (sub == SUB_LAST) ? SUB_SET : sub + 2'd1;
          end else if (bit_step == STEP_ACK_SET) begin
            // ack every byte but the last, which gets a nak
            sda_level_next = last_byte;
            bit_step_next  = STEP_ACK_HIGH;
          end else if (bit_step == STEP_ACK_HIGH) begin
            scl_level_next = 1'b1;
            bit_step_next  = bit_step + 5'd1;
          end else begin
            scl_level_next = 1'b0;
            bit_step_next  = 5'd0;
            sub_next       = SUB_SET;
            if (last_byte) begin
              phase_next = PH_STOP_END;
            end else begin
              byte_index_next = next_index[7:0];
              shift_byte_next = 8'd0;
            end
          end
        end
        PH_DEV_W, PH_ADDR_H, PH_ADDR_L, PH_WDATA, PH_DEV_R: begin
          if (bit_step < STEP_ACK_SET) begin
            case (sub)
              SUB_SET:  sda_level_next = ((shift_byte & MSB_MASK) != 8'd0);
              SUB_HIGH: scl_level_next = 1'b1;
              default: begin
                scl_level_next  = 1'b0;
                shift_byte_next = {shift_byte[6:0], 1'b0};
              end
            endcase
            bit_step_next = bit_step + 5'd1;
            sub_next      = (sub == SUB_LAST) ? SUB_SET : sub + 2'd1;
          end else if (bit_step == STEP_ACK_SET) begin
            sda_level_next = 1'b1;
            bit_step_next  = STEP_ACK_HIGH;
          end else if (bit_step == STEP_ACK_HIGH) begin
            scl_level_next = 1'b1;
            bit_step_next  = bit_step + 5'd1;
            // fetch the next data byte one item ahead of its use
            rd_en   = 1'b1;
            rd_addr = (phase == PH_ADDR_L) ? '0 : next_index[AW-1:0];
          end else begin
            scl_level_next = 1'b0;
            bit_step_next  = 5'd0;
            sub_next       = SUB_SET;
            if (op.sda_in) begin
              // slave nak, stop driving without a stop condition
              phase_next = PH_IDLE;
              done       = 1'b1;
              status     = ST_NAK;
            end else begin
              case (phase)
                PH_DEV_W: begin
                  phase_next      = PH_ADDR_H;
                  shift_byte_next = saved_addr_high;
                end
                PH_ADDR_H: begin
                  phase_next      = PH_ADDR_L;
                  shift_byte_next = saved_addr_low;
                end
                PH_ADDR_L: begin
                  if (is_read) begin
                    phase_next = PH_STOP_MID;
                  end else if (saved_count == 8'd0) begin
                    phase_next = PH_STOP_END;
                  end else begin
                    phase_next      = PH_WDATA;
                    byte_index_next = 8'd0;
                    shift_byte_next = rd_data;
                  end
                end
                PH_WDATA: begin
                  byte_index_next = next_index[7:0];
                  if (last_byte) begin
                    phase_next = PH_STOP_END;
                  end else begin
                    shift_byte_next = rd_data;
                  end
                end
                default: begin
                  phase_next      = PH_RDATA;
                  byte_index_next = 8'd0;
                  shift_byte_next = 8'd0;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.scl_out  = scl_level_next;
    result.sda_out  = sda_level_next;
    result.busy_res = (phase_next != PH_IDLE);
    result.rx_data  = rx_data;
    result.rx_valid = rx_valid;
    result.rx_last  = rx_last;
    result.done_res = done;
    result.status   = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_step     <= 5'd0;
      sub          <= SUB_SET;
      byte_index   <= 8'd0;
      is_read      <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      loaded_bytes <= '0;
    end else if (go) begin
      phase        <= phase_next;
      bit_step     <= bit_step_next;
      sub          <= sub_next;
      byte_index   <= byte_index_next;
      is_read      <= is_read_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
      loaded_bytes <= loaded_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      shift_byte      <= shift_byte_next;
      saved_device    <= saved_device_next;
      saved_addr_high <= saved_addr_high_next;
      saved_addr_low  <= saved_addr_low_next;
      saved_count     <= saved_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && wr_en) begin
      buf_mem[loaded_bytes[AW-1:0]] <= op.data;
    end
    if (go && rd_en) begin
      rd_data <= buf_mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/i2c_eeprom_master_sequencer_top.sv -----
// top level of the i2c eeprom master sequencer
// depends on iems_pkg, iems_fifo, iems_front and iems_back
//
// usage
// - request channel: an item is taken at a clock edge with push high and full
//   low; cmd picks tick, load write byte, start write or start read
// - result channel: the oldest result sits on result while empty is low and
//   is taken at an edge with pop high; exactly one result per request item
// - each tick item moves scl and sda one waveform step; a byte on the bus
//   costs 27 ticks, start and stop four ticks each
// - path: front queue, then the back end step, then the result queue
// - throughput: one item per cycle while the result queue has room, set
//   by the back end's combinational step and its one buffer access per item
// - a two-entry queue parts the decoder from the sequencer and another
//   holds results, so a stalled receiver lets the front keep taking items
//   until both queues fill, then full rises
// - reset: queues empty, bus lines released high, sequencer idle, write
//   buffer count zero; buffer contents are not cleared and need no sweep
// - commands other than tick are ignored while busy_res is high
module i2c_eeprom_master_sequencer_top import iems_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  request_t request,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  op_t     op;
  logic    op_valid;
  logic    op_take;
  result_t seq_result;
  logic    seq_push;
  logic    res_full;

  // decode and queue incoming items
  iems_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .request  (request),
    .full     (full),
    .op       (op),
    .op_valid (op_valid),
    .op_take  (op_take)
  );

  // waveform sequencer, runs whenever an item waits and the result queue has room
  iems_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .op_valid    (op_valid),
    .op_take     (op_take),
    .result      (seq_result),
    .result_push (seq_push),
    .result_full (res_full)
  );

  // result queue toward the receiver
  iems_fifo #(.item_t(result_t)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (seq_push),
    .wdata (seq_result),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ----- tb/iems_bus_checker.sv -----
`timescale 1ns / 100ps
// checker for the i2c eeprom master sequencer: watches both queue-style channels,
// steps its own copy of the bus waveform per accepted item and compares results
// depends on iems_pkg
module iems_bus_checker import iems_pkg::*; #(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  logic     full,
  input  request_t request,
  input  logic     pop,
  input  logic     empty,
  input  result_t  result,
  output int       mismatches,
  output int       outstanding
);

  // mirrored sequencer state
  logic [7:0] wbuf [BUF_DEPTH];
  int         loaded;
  phase_t     ph;
  int         step;
  logic [7:0] bidx, shreg, dev, addr_hi, addr_lo, cnt;
  logic       rd, scl, sda;

  result_t    predicted_bus_results [$];

  // one waveform step of the sequencer for one accepted item
  function automatic result_t advance_bus_model(request_t r);
    result_t res;
    int      s;
    logic    last_byte;
    res = '0;
    s = step;
    if (ph == PH_IDLE) begin
      if (r.cmd == CMD_LOAD) begin
        if (loaded < BUF_DEPTH) begin
          wbuf[loaded] = r.data;
          loaded++;
        end
      end else if (r.cmd == CMD_WRITE || r.cmd == CMD_READ) begin
        if ((r.cmd == CMD_READ && r.count == 0) || (r.cmd == CMD_WRITE && r.count > loaded)) begin
          res.done_res = 1'b1;
          res.status = ST_BAD;
        end else begin
          rd = (r.cmd == CMD_READ);
          dev = r.device_address;
          addr_hi = r.word_address_high;
          addr_lo = r.word_address_low;
          cnt = r.count;
          if (!rd) loaded = 0;
          ph = PH_START_A;
          step = 0;
          bidx = '0;
        end
      end
    end else if (r.cmd == CMD_TICK) begin
      case (ph)
        PH_START_A, PH_START_B: begin
          case (s)
            0: scl = 1'b1;
            1: sda = 1'b1;
            2: sda = 1'b0;
            default: scl = 1'b0;
          endcase
          if (s >= 3) begin
            step = 0;
            if (ph == PH_START_A) begin
              ph = PH_DEV_W;
              shreg = dev;
            end else begin
              ph = PH_DEV_R;
              shreg = dev + 8'd1;
            end
          end else begin
            step = s + 1;
          end
        end
        PH_STOP_MID, PH_STOP_END: begin
          case (s)
            0: sda = 1'b0;
            1: scl = 1'b1;
            2: sda = 1'b1;
            default: scl = 1'b1;
          endcase
          if (s >= 3) begin
            step = 0;
            if (ph == PH_STOP_MID) begin
              ph = PH_START_B;
            end else begin
              ph = PH_IDLE;
              res.done_res = 1'b1;
              res.status = ST_OK;
            end
          end else begin
            step = s + 1;
          end
        end
        PH_RDATA: begin
          last_byte = (int'(bidx) + 1 >= int'(cnt));
          if (s < 24) begin
            case (s % 3)
              0: sda = 1'b1;
              1: scl = 1'b1;
              default: begin
                scl = 1'b0;
                shreg = {shreg[6:0], r.sda_in};
                if (s == 23) begin
                  res.rx_valid = 1'b1;
                  res.rx_data = shreg;
                  res.rx_last = last_byte;
                end
              end
            endcase
            step = s + 1;
          end else if (s == 24) begin
            sda = last_byte;
            step = 25;
          end else if (s == 25) begin
            scl = 1'b1;
            step = 26;
          end else begin
            scl = 1'b0;
            step = 0;
            if (last_byte) begin
              ph = PH_STOP_END;
            end else begin
              bidx = bidx + 8'd1;
              shreg = '0;
            end
          end
        end
        default: begin
          // sending phases, msb first, ack sampled as scl falls
          if (s < 24) begin
            case (s % 3)
              0: sda = |((shreg << (s / 3)) & MSB_MASK);
              1: scl = 1'b1;
              default: scl = 1'b0;
            endcase
            step = s + 1;
          end else if (s == 24) begin
            sda = 1'b1;
            step = 25;
          end else if (s == 25) begin
            scl = 1'b1;
            step = 26;
          end else begin
            scl = 1'b0;
            step = 0;
            if (r.sda_in) begin
              ph = PH_IDLE;
              res.done_res = 1'b1;
              res.status = ST_NAK;
            end else begin
              case (ph)
                PH_DEV_W: begin
                  ph = PH_ADDR_H;
                  shreg = addr_hi;
                end
                PH_ADDR_H: begin
                  ph = PH_ADDR_L;
                  shreg = addr_lo;
                end
                PH_ADDR_L: begin
                  if (rd) ph = PH_STOP_MID;
                  else if (cnt == 0) ph = PH_STOP_END;
                  else begin
                    ph = PH_WDATA;
                    bidx = '0;
                    shreg = wbuf[0];
                  end
                end
                PH_WDATA: begin
                  bidx = bidx + 8'd1;
                  if (bidx >= cnt) ph = PH_STOP_END;
                  else shreg = wbuf[bidx];
                end
                default: begin
                  ph = PH_RDATA;
                  bidx = '0;
                  shreg = '0;
                end
              endcase
            end
          end
        end
      endcase
    end
    res.scl_out = scl;
    res.sda_out = sda;
    res.busy_res = (ph != PH_IDLE);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      foreach (wbuf[i]) wbuf[i] = '0;
      loaded = 0;
      ph = PH_IDLE;
      step = 0;
      bidx = '0;
      shreg = '0;
      dev = '0;
      addr_hi = '0;
      addr_lo = '0;
      cnt = '0;
      rd = 1'b0;
      scl = 1'b1;
      sda = 1'b1;
      mismatches = 0;
      predicted_bus_results.delete();
    end else begin
      // a result can never belong to an item taken at the same edge
      if (pop && !empty) begin
        if (predicted_bus_results.size() == 0) begin
          $error("result %0h arrived with no item waiting", result);
          mismatches++;
        end else begin
          want = predicted_bus_results.pop_front();
          compare_field("scl_out", want.scl_out, result.scl_out);
          compare_field("sda_out", want.sda_out, result.sda_out);
          compare_field("busy_res", want.busy_res, result.busy_res);
          compare_field("rx_data", want.rx_data, result.rx_data);
          compare_field("rx_valid", want.rx_valid, result.rx_valid);
          compare_field("rx_last", want.rx_last, result.rx_last);
          compare_field("done_res", want.done_res, result.done_res);
          compare_field("status", want.status, result.status);
        end
      end
      if (push && !full) predicted_bus_results.push_back(advance_bus_model(request));
    end
    outstanding = predicted_bus_results.size();
  end

endmodule

// ----- tb/i2c_eeprom_master_sequencer_top_tb.sv -----
`timescale 1ns / 100ps
// testbench top for the i2c eeprom master sequencer: drives eeprom write and read
// transfers with acks, naks, refusals and stray commands, and gives the verdict
// depends on iems_pkg, the block's rtl and iems_bus_checker
module i2c_eeprom_master_sequencer_top_tb import iems_pkg::*; ();

  localparam int REQ_W = $bits(request_t);

  logic     clk, rst, push, full, empty, pop;
  request_t request;
  result_t  result;
  int       mismatches, outstanding;

  // receiver control: hold-off length in cycles, and a no-stall stretch flag
  int       rx_hold = 0;
  bit       rx_quiet = 1'b0;
  bit       tx_quiet = 1'b0;

  // what the sender knows of the block: bytes sitting in the write buffer
  int       buffered = 0;
  int       items = 0;

  i2c_eeprom_master_sequencer_top dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  iems_bus_checker bus_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .request     (request),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: pops at random, honors a hold-off that it counts down itself
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        pop = 1'b0;
        rx_hold--;
      end else begin
        pop = rx_quiet || ($urandom_range(99) >= 37);
      end
    end
  end

  // offer one item from a falling edge, hold it until taken, return at the next falling edge
  task automatic send_item(input request_t r, input bit counted);
    while (!tx_quiet && $urandom_range(99) < 37) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    request = r;
    do @(posedge clk); while (full);
    @(negedge clk);
    if (counted) items++;
  endtask

  // every field random, command fixed
  function automatic request_t any_request(cmd_t c);
    request_t r;
    r = REQ_W'({$urandom, $urandom});
    r.cmd = c;
    return r;
  endfunction

  task automatic load_one(input logic [7:0] value);
    request_t r;
    r = any_request(CMD_LOAD);
    r.data = value;
    send_item(r, 1'b1);
    // loads beyond the buffer depth are dropped
    if (buffered < BUF_DEPTH_DEF) buffered++;
  endtask

  task automatic load_bytes(input int n);
    repeat (n) load_one(8'($urandom));
  endtask

  task automatic idle_tick(input logic level);
    request_t r;
    r = any_request(CMD_TICK);
    r.sda_in = level;
    send_item(r, 1'b1);
  endtask

  // one write or read request followed by the ticks that run it to its end
  // ack slots: device, address high, address low, then write data bytes or the read device byte
  // nak_slot picks the slot that sees a nak, -1 for none
  task automatic transfer(input request_t req, input int nak_slot, input int noise_pct);
    request_t r;
    bit       rd, refused;
    int       total, slot;
    rd = (req.cmd == CMD_READ);
    refused = rd ? (req.count == 0) : (req.count > buffered);
    send_item(req, 1'b1);
    if (refused) return;
    if (!rd) buffered = 0;
    // start 4, 27 per byte, stop 4; a read adds stop, restart and the read device byte
    total = rd ? 124 + 27 * req.count : 8 + 27 * (req.count + 3);
    for (int t = 1; t <= total; t++) begin
      // stray commands while busy must be ignored
      if ($urandom_range(99) < noise_pct)
        send_item(any_request(cmd_t'($urandom_range(1, 3))), 1'b0);
      slot = -1;
      if (t >= 31 && (t - 31) % 27 == 0 && (t - 31) / 27 < (rd ? 3 : req.count + 3))
        slot = (t - 31) / 27;
      if (rd && t == 120) slot = 3;
      r = any_request(CMD_TICK);
      // ack slots see a clean ack or the chosen nak; data and other ticks get random sda
      if (slot >= 0) r.sda_in = (slot == nak_slot);
      send_item(r, 1'b1);
      if (slot >= 0 && slot == nak_slot) return;
    end
  endtask

  initial begin : stimulus
    request_t r;
    int       pick, n, nak;
    bit       rd;
    rst = 1'b1;
    push = 1'b0;
    request = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle ticks with both line levels
    idle_tick(1'b0);
    idle_tick(1'b1);

    // read with zero count is refused
    r = any_request(CMD_READ);
    r.count = 8'd0;
    transfer(r, -1, 0);

    // write longer than the loaded data is refused
    r = any_request(CMD_WRITE);
    r.count = 8'd1;
    transfer(r, -1, 0);

    // zero-length write: addresses then stop
    r = any_request(CMD_WRITE);
    r.count = 8'd0;
    r.device_address = 8'h00;
    r.word_address_high = 8'hFF;
    r.word_address_low = 8'h00;
    transfer(r, -1, 0);

    // two-byte read, device byte wraps from ff to 00, master acks then naks
    r = any_request(CMD_READ);
    r.count = 8'd2;
    r.device_address = 8'hFF;
    transfer(r, -1, 0);

    // slave nak on the data byte of a one-byte write
    load_bytes(1);
    r = any_request(CMD_WRITE);
    r.count = 8'd1;
    transfer(r, 3, 0);

    // receiver holds off while the buffer fills past its depth, so both queues fill
    // and full rises; the extra load is dropped
    rx_hold = 400;
    load_one(8'h00);
    load_one(8'hFF);
    load_bytes(BUF_DEPTH_DEF - 1);

    // sender waits until every result is back
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);

    // no idling on either side: write of the data extremes with stray commands
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    r = any_request(CMD_WRITE);
    r.count = 8'd3;
    r.device_address = 8'hFF;
    r.word_address_high = 8'h00;
    r.word_address_low = 8'hFF;
    transfer(r, -1, 20);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    // random part: mostly well-formed transfers, some naks, refusals and stray items
    while (items < 900) begin
      pick = $urandom_range(99);
      if (pick >= 80) begin
        // stray loads and idle ticks between transfers
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(1)) load_one(8'($urandom));
          else idle_tick(1'($urandom_range(1)));
        end
        continue;
      end
      rd = (pick >= 40);
      if (rd) begin
        if ($urandom_range(9) == 0) n = 0;
        else if ($urandom_range(19) == 0) n = $urandom_range(1, 32);
        else n = $urandom_range(1, 4);
      end else begin
        load_bytes($urandom_range(0, 4));
        if ($urandom_range(9) == 0) n = $urandom_range(255);
        else n = $urandom_range(0, buffered < 6 ? buffered : 6);
      end
      nak = ($urandom_range(4) == 0) ? int'($urandom_range(0, rd ? 3 : n + 2)) : -1;
      r = any_request(rd ? CMD_READ : CMD_WRITE);
      r.count = 8'(n);
      transfer(r, nak, 5);
    end

    // drain, then let the block idle so any stray result can show before the verdict
    push = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/iems_pkg.sv
hw/rtl/iems_fifo.sv
hw/rtl/iems_front.sv
hw/rtl/iems_back.sv
hw/rtl/i2c_eeprom_master_sequencer_top.sv
tb/iems_bus_checker.sv
tb/i2c_eeprom_master_sequencer_top_tb.sv
